### rtl/tle_pkg.sv
// Shared constants, types and arithmetic helpers for the tilt level estimator.
package tle_pkg;

  localparam int SAMPLE_W = 16;
  localparam int ANGLE_W = 16;
  localparam int BUBBLE_W = 11;
  localparam int SCALE_W = 6;
  localparam int MAXO_W = 10;
  localparam int TOL_W = 7;
  localparam int CFG_W = 10;
  localparam int CFG_IDX_W = 2;

  localparam int FILT_SHIFT = 3;
  localparam int TILT_GAIN = 5730;
  localparam int TILT_DIV = 100;
  localparam int Z_FLOOR = 100;
  localparam int SMOOTH_Z_RESET = 1000;

  localparam int MAG_W = SAMPLE_W + 1;
  localparam int NUM_W = MAG_W + $clog2(TILT_GAIN);
  localparam int DEN_W = MAG_W + $clog2(TILT_DIV);
  localparam int CNT_W = $clog2(NUM_W);

  localparam int IN_TDATA_W = ((3 * SAMPLE_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * ANGLE_W + 2 * BUBBLE_W + 1;
  localparam int OUT_TDATA_W = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_SCALE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAX_OFFSET = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TOL = CFG_IDX_W'(2);

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef struct packed {
    logic [SCALE_W-1:0] offset_scale;
    logic [MAXO_W-1:0]  max_offset;
    logic [TOL_W-1:0]   level_tolerance;
  } cfg_t;

  typedef struct packed {
    logic [NUM_W-1:0] num_x;
    logic [NUM_W-1:0] num_y;
    logic [DEN_W-1:0] den;
    logic             neg_x;
    logic             neg_y;
  } job_t;

  typedef struct packed {
    logic signed [ANGLE_W-1:0]  pitch_deg;
    logic signed [ANGLE_W-1:0]  roll_deg;
    logic signed [BUBBLE_W-1:0] bubble_dx;
    logic signed [BUBBLE_W-1:0] bubble_dy;
    logic                       is_level;
  } result_t;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [NUM_W-1:0] acc;
  } div_lane_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_FIN
  } back_state_t;

  // s = (7s + a) / 8, truncated toward zero, wrapped to the sample width
  function automatic sample_t lowpass(input sample_t s, input sample_t a);
    logic signed [SAMPLE_W+3:0] se;
    logic signed [SAMPLE_W+3:0] ae;
    logic signed [SAMPLE_W+3:0] t;
    logic signed [SAMPLE_W+3:0] u;
    se = {{4{s[SAMPLE_W-1]}}, s};
    ae = {{4{a[SAMPLE_W-1]}}, a};
    t = (se <<< FILT_SHIFT) - se + ae;
    u = t[SAMPLE_W+3] ? t + (SAMPLE_W+4)'(7) : t;
    return u[SAMPLE_W+2:FILT_SHIFT];
  endfunction

  function automatic sample_t clamp_z(input sample_t z);
    sample_t zf;
    zf = SAMPLE_W'(Z_FLOOR);
    if (z < zf && z > -zf) begin
      return z[SAMPLE_W-1] ? -zf : zf;
    end
    return z;
  endfunction

  function automatic logic [MAG_W-1:0] magnitude(input sample_t v);
    logic signed [MAG_W-1:0] ve;
    ve = {v[SAMPLE_W-1], v};
    return v[SAMPLE_W-1] ? MAG_W'(-ve) : MAG_W'(ve);
  endfunction

  // one restoring step of an unsigned divide; quotient bits replace dividend bits
  function automatic div_lane_t div_step(input div_lane_t l, input logic [DEN_W-1:0] den);
    logic [DEN_W:0] sh;
    logic [DEN_W:0] diff;
    div_lane_t      r;
    sh = {l.rem, l.acc[NUM_W-1]};
    diff = sh - {1'b0, den};
    if (!diff[DEN_W]) begin
      r.rem = diff[DEN_W-1:0];
      r.acc = {l.acc[NUM_W-2:0], 1'b1};
    end else begin
      r.rem = sh[DEN_W-1:0];
      r.acc = {l.acc[NUM_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

### rtl/tilt_level_estimator.sv
// Top level of the tilt level estimator: configuration registers, stream ports, front and back.
// The divider's 30 one-bit steps set the throughput; it pops a new job only once a result loads.
// The front end and a two-entry queue take up to three samples ahead of the divider.
// Reset: synchronous; filters return to x=0, y=0, z=1000 and registers to 6, 64 and 1.
// Reset clears the queue and drops any pending result.
module tilt_level_estimator (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_tvalid,
  output logic                               s_tready,
  input  logic [tle_pkg::IN_TDATA_W-1:0]     s_tdata,   // accel_x, accel_y, accel_z
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [tle_pkg::OUT_TDATA_W-1:0]    m_tdata,   // pitch_deg, roll_deg, bubble_dx,
                                                        // bubble_dy, is_level, zero pad
  input  logic                               cfg_we,
  input  logic [tle_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [tle_pkg::CFG_W-1:0]          cfg_wdata
);
  import tle_pkg::*;

  cfg_t    cfg;
  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  job_t    wr_job;
  job_t    rd_job;
  result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.offset_scale <= SCALE_W'(6);
      cfg.max_offset <= MAXO_W'(64);
      cfg.level_tolerance <= TOL_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_OFFSET_SCALE: cfg.offset_scale <= cfg_wdata[SCALE_W-1:0];
        REG_MAX_OFFSET:   cfg.max_offset <= cfg_wdata[MAXO_W-1:0];
        REG_LEVEL_TOL:    cfg.level_tolerance <= cfg_wdata[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  tle_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .accel_x  (s_tdata[SAMPLE_W-1:0]),
    .accel_y  (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
    .accel_z  (s_tdata[3*SAMPLE_W-1:2*SAMPLE_W]),
    .q_push   (q_push),
    .q_job    (wr_job),
    .q_full   (q_full)
  );

  tle_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .wr_job (wr_job),
    .full   (q_full),
    .pop    (q_pop),
    .rd_job (rd_job),
    .empty  (q_empty)
  );

  tle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .q_job     (rd_job),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (res)
  );

  assign m_tdata = OUT_TDATA_W'({res.is_level, res.bubble_dy, res.bubble_dx,
                                 res.roll_deg, res.pitch_deg});

endmodule

### rtl/tle_front.sv
// Front end: accepts samples, runs the smoothing filters and builds divide requests.
module tle_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tle_pkg::sample_t       accel_x,
  input  tle_pkg::sample_t       accel_y,
  input  tle_pkg::sample_t       accel_z,
  output logic                   q_push,
  output tle_pkg::job_t          q_job,
  input  logic                   q_full
);
  import tle_pkg::*;

  sample_t          smooth_x;
  sample_t          smooth_y;
  sample_t          smooth_z;
  logic             pend;
  logic             accept;
  sample_t          zc;
  logic [MAG_W-1:0] mag_x;
  logic [MAG_W-1:0] mag_y;
  logic [MAG_W-1:0] mag_z;

  assign q_push = pend && !q_full;
  assign in_ready = !pend || !q_full;
  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      smooth_x <= '0;
      smooth_y <= '0;
      smooth_z <= SAMPLE_W'(SMOOTH_Z_RESET);
      pend <= 1'b0;
    end else begin
      if (accept) begin
        smooth_x <= lowpass(smooth_x, accel_x);
        smooth_y <= lowpass(smooth_y, accel_y);
        smooth_z <= lowpass(smooth_z, accel_z);
        pend <= 1'b1;
      end else if (q_push) begin
        pend <= 1'b0;
      end
    end
  end

  always_comb begin
    zc = clamp_z(smooth_z);
    mag_x = magnitude(smooth_x);
    mag_y = magnitude(smooth_y);
    mag_z = magnitude(zc);
    q_job.num_x = NUM_W'(mag_x) * NUM_W'(TILT_GAIN);
    q_job.num_y = NUM_W'(mag_y) * NUM_W'(TILT_GAIN);
    q_job.den = DEN_W'(mag_z) * DEN_W'(TILT_DIV);
    q_job.neg_x = smooth_x[SAMPLE_W-1] ^ zc[SAMPLE_W-1];
    q_job.neg_y = smooth_y[SAMPLE_W-1] ^ zc[SAMPLE_W-1];
  end

endmodule

### rtl/tle_queue.sv
// Two-entry request queue between the front end and the divide back end.
module tle_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  tle_pkg::job_t wr_job,
  output logic          full,
  input  logic          pop,
  output tle_pkg::job_t rd_job,
  output logic          empty
);
  import tle_pkg::*;

  job_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rd_job = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/tle_back.sv
// Back end: two radix-2 dividers sharing one divisor, then offsets, level flag and output register.
module tle_back (
  input  logic             clk,
  input  logic             rst,
  input  tle_pkg::cfg_t    cfg,
  input  logic             q_empty,
  input  tle_pkg::job_t    q_job,
  output logic             q_pop,
  output logic             out_valid,
  input  logic             out_ready,
  output tle_pkg::result_t out_res
);
  import tle_pkg::*;

  back_state_t       state;
  back_state_t       state_next;
  logic [CNT_W-1:0]  cnt;
  div_lane_t         lane_x;
  div_lane_t         lane_y;
  logic [DEN_W-1:0]  den;
  logic              neg_x;
  logic              neg_y;
  logic              step;
  logic              load_out;
  logic              last_step;
  result_t           res_next;

  logic signed [ANGLE_W-1:0]  roll;
  logic signed [ANGLE_W-1:0]  pitch;
  logic signed [ANGLE_W+6:0]  prod_x;
  logic signed [ANGLE_W+6:0]  prod_y;
  logic signed [ANGLE_W+6:0]  d_x;
  logic signed [ANGLE_W+6:0]  d_y;
  logic signed [ANGLE_W+6:0]  lim;
  logic signed [ANGLE_W+6:0]  sat_x;
  logic signed [ANGLE_W+6:0]  sat_y;
  logic signed [ANGLE_W+6:0]  scale_s;

  assign last_step = (cnt == CNT_W'(NUM_W - 1));

  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: if (!q_empty) state_next = BK_DIV;
      BK_DIV:  if (last_step) state_next = BK_FIN;
      BK_FIN:  if (!out_valid || out_ready) state_next = BK_IDLE;
      default: state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop = 1'b0;
    step = 1'b0;
    load_out = 1'b0;
    unique case (state)
      BK_IDLE: q_pop = !q_empty;
      BK_DIV:  step = 1'b1;
      BK_FIN:  load_out = !out_valid || out_ready;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      lane_x <= '{rem: '0, acc: q_job.num_x};
      lane_y <= '{rem: '0, acc: q_job.num_y};
      den <= q_job.den;
      neg_x <= q_job.neg_x;
      neg_y <= q_job.neg_y;
      cnt <= '0;
    end else if (step) begin
      lane_x <= div_step(lane_x, den);
      lane_y <= div_step(lane_y, den);
      cnt <= cnt + CNT_W'(1);
    end
    if (load_out) begin
      out_res <= res_next;
    end
  end

  // roll from x lane, pitch from y lane; offsets are minus angle times scale, clamped to max offset
  always_comb begin
    roll = neg_x ? -$signed(lane_x.acc[ANGLE_W-1:0]) : $signed(lane_x.acc[ANGLE_W-1:0]);
    pitch = neg_y ? -$signed(lane_y.acc[ANGLE_W-1:0]) : $signed(lane_y.acc[ANGLE_W-1:0]);
    scale_s = $signed((ANGLE_W+7)'(cfg.offset_scale));
    lim = $signed((ANGLE_W+7)'(cfg.max_offset));
    prod_x = (ANGLE_W+7)'(roll) * scale_s;
    prod_y = (ANGLE_W+7)'(pitch) * scale_s;
    d_x = -prod_x;
    d_y = -prod_y;
    if (d_x > lim) sat_x = lim;
    else if (d_x < -lim) sat_x = -lim;
    else sat_x = d_x;
    if (d_y > lim) sat_y = lim;
    else if (d_y < -lim) sat_y = -lim;
    else sat_y = d_y;
    res_next.pitch_deg = pitch;
    res_next.roll_deg = roll;
    res_next.bubble_dx = sat_x[BUBBLE_W-1:0];
    res_next.bubble_dy = sat_y[BUBBLE_W-1:0];
    res_next.is_level = (lane_x.acc[ANGLE_W-1:0] <= ANGLE_W'(cfg.level_tolerance)) &&
                        (lane_y.acc[ANGLE_W-1:0] <= ANGLE_W'(cfg.level_tolerance));
  end

endmodule

### test/tilt_checker.sv
// Checker for the tilt level estimator: watches the ports, predicts each result, compares it.
module tilt_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [tle_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [tle_pkg::OUT_TDATA_W-1:0] m_tdata,
  input  logic                            cfg_we,
  input  logic [tle_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tle_pkg::CFG_W-1:0]       cfg_wdata,
  output int                              mismatches,
  output int                              outstanding
);
  import tle_pkg::*;

  localparam int SCALE_RESET = 6;
  localparam int MAXO_RESET = 64;
  localparam int TOL_RESET = 1;
  localparam int FILT_DIV = 1 << FILT_SHIFT;

  localparam int ROLL_LSB = ANGLE_W;
  localparam int DX_LSB = 2 * ANGLE_W;
  localparam int DY_LSB = DX_LSB + BUBBLE_W;
  localparam int LEVEL_BIT = DY_LSB + BUBBLE_W;

  logic [SCALE_W-1:0] scale;
  logic [MAXO_W-1:0]  max_off;
  logic [TOL_W-1:0]   tol;
  sample_t            filt_x;
  sample_t            filt_y;
  sample_t            filt_z;
  result_t            tilt_q[$];
  int                 errs = 0;

  function automatic sample_t filt_next(sample_t s, sample_t a);
    longint acc;
    acc = (longint'(s) * (FILT_DIV - 1) + longint'(a)) / FILT_DIV;
    return sample_t'(acc);
  endfunction

  function automatic longint tilt_of(longint lateral, longint z);
    if (z < Z_FLOOR && z > -Z_FLOOR) z = (z < 0) ? -Z_FLOOR : Z_FLOOR;
    return ((lateral * TILT_GAIN) / z) / TILT_DIV;
  endfunction

  function automatic logic signed [BUBBLE_W-1:0] bubble_of(longint angle, longint gain,
                                                          longint lim);
    longint d;
    d = -angle * gain;
    if (d > lim) d = lim;
    if (d < -lim) d = -lim;
    return BUBBLE_W'(d);
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  task automatic check_field(string name, longint want, longint got);
    if (want != got) begin
      if (errs < 10) $display("tilt_checker: %s expected %0d, got %0d", name, want, got);
      errs++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    longint  pitch;
    longint  roll;
    if (rst) begin
      scale = SCALE_W'(SCALE_RESET);
      max_off = MAXO_W'(MAXO_RESET);
      tol = TOL_W'(TOL_RESET);
      filt_x = '0;
      filt_y = '0;
      filt_z = SAMPLE_W'(SMOOTH_Z_RESET);
      tilt_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_OFFSET_SCALE: scale = cfg_wdata[SCALE_W-1:0];
          REG_MAX_OFFSET:   max_off = cfg_wdata[MAXO_W-1:0];
          REG_LEVEL_TOL:    tol = cfg_wdata[TOL_W-1:0];
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        filt_x = filt_next(filt_x, s_tdata[0 +: SAMPLE_W]);
        filt_y = filt_next(filt_y, s_tdata[SAMPLE_W +: SAMPLE_W]);
        filt_z = filt_next(filt_z, s_tdata[2*SAMPLE_W +: SAMPLE_W]);
        pitch = tilt_of(filt_y, filt_z);
        roll = tilt_of(filt_x, filt_z);
        want.pitch_deg = ANGLE_W'(pitch);
        want.roll_deg = ANGLE_W'(roll);
        want.bubble_dx = bubble_of(roll, longint'(scale), longint'(max_off));
        want.bubble_dy = bubble_of(pitch, longint'(scale), longint'(max_off));
        want.is_level = (mag(pitch) <= longint'(tol)) && (mag(roll) <= longint'(tol));
        tilt_q.push_back(want);
      end
      if (m_tvalid && m_tready) begin
        if (tilt_q.size() == 0) begin
          if (errs < 10) $display("tilt_checker: unexpected result %h", m_tdata);
          errs++;
        end else begin
          want = tilt_q.pop_front();
          check_field("pitch_deg", want.pitch_deg, $signed(m_tdata[0 +: ANGLE_W]));
          check_field("roll_deg", want.roll_deg, $signed(m_tdata[ROLL_LSB +: ANGLE_W]));
          check_field("bubble_dx", want.bubble_dx, $signed(m_tdata[DX_LSB +: BUBBLE_W]));
          check_field("bubble_dy", want.bubble_dy, $signed(m_tdata[DY_LSB +: BUBBLE_W]));
          check_field("is_level", want.is_level, m_tdata[LEVEL_BIT]);
        end
      end
    end
    mismatches <= errs;
    outstanding <= tilt_q.size();
  end

endmodule

### test/tb_top.sv
// Testbench top for the tilt level estimator: reset, register setup, sample stimulus, verdict.
module tb_top;
  import tle_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);
  localparam int MAX_WAIT = 19;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 40;
  localparam int QUIET_LIMIT = 3000;
  localparam longint S_MIN = -(longint'(1) <<< (SAMPLE_W - 1));
  localparam longint S_MAX = (longint'(1) <<< (SAMPLE_W - 1)) - 1;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_W-1:0]       cfg_wdata = '0;

  int      mismatches;
  int      outstanding;
  int      quiet_cycles = 0;
  bit      no_idle = 1'b0;
  bit      hold_req = 1'b0;
  sample_t tgt_x;
  sample_t tgt_y;
  sample_t tgt_z;
  int      tgt_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  tilt_level_estimator i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  tilt_checker i_chk (
    .clk         (clk),
    .rst         (rst),
    .s_tvalid    (s_tvalid),
    .s_tready    (s_tready),
    .s_tdata     (s_tdata),
    .m_tvalid    (m_tvalid),
    .m_tready    (m_tready),
    .m_tdata     (m_tdata),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  function automatic sample_t clip_sample(longint v);
    if (v > S_MAX) v = S_MAX;
    if (v < S_MIN) v = S_MIN;
    return sample_t'(v);
  endfunction

  function automatic sample_t jitter(sample_t c);
    return clip_sample(longint'(c) + int'($urandom_range(0, 60)) - 30);
  endfunction

  function automatic sample_t pick_extreme();
    case ($urandom_range(0, 3))
      0: return sample_t'(S_MIN);
      1: return sample_t'(S_MAX);
      2: return '0;
      default: return '1;
    endcase
  endfunction

  function automatic sample_t pick_lateral();
    case ($urandom_range(0, 3))
      0: return sample_t'(int'($urandom_range(0, 80)) - 40);
      1: return sample_t'(int'($urandom_range(0, 2400)) - 1200);
      2: return sample_t'(int'($urandom_range(0, 16000)) - 8000);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic sample_t pick_vertical();
    int sgn;
    sgn = $urandom_range(0, 1) ? -1 : 1;
    case ($urandom_range(0, 3))
      0: return sample_t'(sgn * int'($urandom_range(900, 1100)));
      1: return sample_t'(int'($urandom_range(0, 300)) - 150);
      2: return sample_t'(sgn * int'($urandom_range(100, 5000)));
      default: return sample_t'($urandom);
    endcase
  endfunction

  // hold a tilt target for a stretch so the filters settle, with noise and outliers
  task automatic next_sample(output sample_t x, output sample_t y, output sample_t z);
    int mode;
    mode = $urandom_range(0, 99);
    if (tgt_left == 0) begin
      tgt_left = $urandom_range(8, 40);
      tgt_x = pick_lateral();
      tgt_y = pick_lateral();
      tgt_z = pick_vertical();
    end
    tgt_left--;
    if (mode < 12) begin
      x = sample_t'($urandom);
      y = sample_t'($urandom);
      z = sample_t'($urandom);
    end else if (mode < 16) begin
      x = pick_extreme();
      y = pick_extreme();
      z = pick_extreme();
    end else begin
      x = jitter(tgt_x);
      y = jitter(tgt_y);
      z = jitter(tgt_z);
    end
  endtask

  task automatic send_sample(sample_t x, sample_t y, sample_t z);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  task automatic send_random(int count);
    sample_t x;
    sample_t y;
    sample_t z;
    repeat (count) begin
      next_sample(x, y, z);
      send_sample(x, y, z);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic program_regs(logic [CFG_W-1:0] scale_v, logic [CFG_W-1:0] maxo_v,
                              logic [CFG_W-1:0] tol_v);
    logic [CFG_IDX_W-1:0] idx [4];
    logic [CFG_W-1:0]     val [4];
    idx = '{REG_OFFSET_SCALE, REG_MAX_OFFSET, REG_LEVEL_TOL, REG_SPARE};
    val = '{scale_v, maxo_v, tol_v, CFG_W'($urandom)};
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[i];
      cfg_wdata <= val[i];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    send_sample(0, 0, 1000);
    send_sample(16, -16, 1000);
    // steer filtered z through 50, -50, 0, -99, 99, 100, -100, -1
    send_sample(32767, -32768, -6600);
    send_sample(32767, -32768, -750);
    send_sample(-32768, 32767, 350);
    send_sample(0, 0, -792);
    send_sample(0, 0, 1485);
    send_sample(100, -100, 107);
    send_sample(-100, 100, -1500);
    send_sample(0, 0, 692);
    send_sample(32767, 32767, 32767);
    send_sample(32767, -32768, 32767);
    send_sample(-32768, 32767, -32768);
    send_sample(-32768, -32768, -32768);
    send_sample(-1, -1, -1);
    send_sample(0, 0, 0);
    send_sample(-32768, 32767, 0);
    drain();

    program_regs(10'd63, 10'd1023, 10'd90);
    send_random(250);
    no_idle = 1'b1;
    send_random(100);
    no_idle = 1'b0;
    drain();

    program_regs(10'd0, 10'd0, 10'd0);
    send_random(120);
    no_idle = 1'b1;
    hold_req = 1'b1;
    send_random(60);
    no_idle = 1'b0;
    send_random(70);
    drain();

    program_regs(CFG_W'($urandom), CFG_W'($urandom), CFG_W'($urandom));
    send_random(300);
    drain();

    // upper data bits set: scale 1, limit 1023, tolerance 127
    program_regs(10'h3C1, 10'h3FF, 10'h37F);
    send_random(300);
    drain();

    program_regs(10'd20, 10'd300, 10'd5);
    send_random(200);
    drain();

    if (mismatches == 0 && outstanding == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

  initial begin
    int stall;
    wait (!rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      stall = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      @(posedge clk);
      while (!m_tvalid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles < QUIET_LIMIT) begin
      quiet_cycles <= quiet_cycles + 1;
    end else begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

endmodule
